>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked out of reset only
`define ASSERT_ON(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> sv/uhp_pkg.sv
// types, constants and header name table of the upgrade header parser
package uhp_pkg;

  localparam int KNOWN_HEADERS    = 10;
  localparam int NAME_STORE_BYTES = 32;
  localparam int CHALLENGE_BYTES  = 8;

  localparam int NAME_LEN_W  = $clog2(NAME_STORE_BYTES);
  localparam int HDR_IDX_W   = 4;
  localparam int LEN_W       = 13;
  localparam int CFG_IDX_W   = 8;
  localparam int HDR_MAX_LEN = 23;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;

  typedef logic [HDR_IDX_W-1:0] hdr_idx_t;
  typedef logic [LEN_W-1:0]     len_t;

  localparam hdr_idx_t IDX_URI       = 4'd0;
  localparam hdr_idx_t IDX_UPGRADE   = 4'd6;
  localparam hdr_idx_t IDX_CHALLENGE = 4'd9;

  // value phases share their code with the header index
  typedef enum logic [3:0] {
    PH_URI, PH_HOST, PH_CONNECTION, PH_KEY1, PH_KEY2, PH_PROTOCOL,
    PH_UPGRADE, PH_ORIGIN, PH_DRAFT, PH_CHALLENGE,
    PH_NAME, PH_SKIP, PH_SKIP_CR, PH_DONE
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_ROOM = 8'd0,
    CFG_GROWTH_STEP  = 8'd1,
    CFG_MAX_ROOM     = 8'd2
  } cfg_reg_t;

  localparam int HDR_LEN [KNOWN_HEADERS] = '{4, 5, 11, 19, 19, 23, 8, 7, 20, 2};

  // names are right-justified, first character in the highest used byte
  localparam logic [HDR_MAX_LEN*8-1:0] HDR_TEXT [KNOWN_HEADERS] = '{
    "GET ", "Host:", "Connection:", "Sec-WebSocket-Key1:",
    "Sec-WebSocket-Key2:", "Sec-WebSocket-Protocol:", "Upgrade:",
    "Origin:", "Sec-WebSocket-Draft:", 16'h0d0a
  };

  function automatic logic [7:0] hdr_char(input int k, input int i);
    int pos;
    pos = (i < HDR_LEN[k]) ? (HDR_LEN[k] - 1 - i) : 0;
    return HDR_TEXT[k][pos*8 +: 8];
  endfunction

  typedef struct packed {
    logic step;
    logic clear;
  } name_ctl_t;

  typedef struct packed {
    logic     full;
    logic     hit;
    hdr_idx_t idx;
  } name_res_t;

  typedef struct packed {
    logic     en;
    hdr_idx_t addr;
    len_t     data;
  } len_wr_t;

  typedef struct packed {
    logic       value_valid;
    hdr_idx_t   header_index;
    logic [7:0] value_byte;
    logic       value_end;
    logic       value_overflow;
    logic       unknown_header;
    logic       name_too_long;
    logic       parse_done;
  } out_item_t;

endpackage

>>> sv/uhp_if.sv
// valid/ready channel interfaces of the upgrade header parser
interface uhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface uhp_out_if;
  logic       valid;
  logic       ready;
  logic       value_valid;
  logic [3:0] header_index;
  logic [7:0] value_byte;
  logic       value_end;
  logic       value_overflow;
  logic       unknown_header;
  logic       name_too_long;
  logic       parse_done;
  modport source (output valid, output value_valid, output header_index,
                  output value_byte, output value_end, output value_overflow,
                  output unknown_header, output name_too_long, output parse_done,
                  input ready);
  modport sink   (input valid, input value_valid, input header_index,
                  input value_byte, input value_end, input value_overflow,
                  input unknown_header, input name_too_long, input parse_done,
                  output ready);
endinterface

interface uhp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [12:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/http_upgrade_header_parser.sv
// top level of the http upgrade request header parser
//
// in_chan carries one request byte per transaction; out_chan returns exactly
// one result per input byte, in order, registered in the cycle after the byte is taken
// cfg_chan writes the room registers (index 0 initial room, 1 growth step,
// 2 maximum room); other indexes are ignored; it is always ready
// throughput is one byte per cycle while in_ready is high: the phase register,
// the prefix flags of the name matcher and the length ram read-modify-write
// all complete for each byte as it is taken, the length being read ahead at
// the address of the next phase and forwarded when the last write hit that entry
// the output register takes a new result whenever it is empty or being
// drained, so in_ready only drops while a result waits and out_ready is low
// reset (rst_n low, synchronous) returns to name collection, clears the
// valid bits of the ten length entries and loads the register defaults
// (256, 64, 4096); no clearing pass is needed
module http_upgrade_header_parser import uhp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  uhp_in_if.sink     in_chan,
  uhp_out_if.source  out_chan,
  uhp_cfg_if.sink    cfg_chan
);

  // room registers
  len_t initial_room_r;
  len_t growth_step_r;
  len_t max_room_r;

  // parse state
  phase_t phase_r;
  phase_t phase_nxt;
  len_t   value_room_r;
  len_t   room_nxt;

  // output register
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t res;

  logic       accept;
  logic [7:0] c;
  len_t       cur_len;
  len_t       len_inc;
  logic [LEN_W:0] len_plus1;
  logic [LEN_W:0] grown;
  logic       abandon;
  hdr_idx_t   cur_idx;
  hdr_idx_t   rd_addr;
  name_ctl_t  name_ctl;
  name_ctl_t  name_ctl_g;
  name_res_t  nres;
  len_wr_t    len_wr;
  len_wr_t    len_wr_g;

  // outside the value phases the upgrade length is kept on the read port
  function automatic hdr_idx_t len_addr(input phase_t ph);
    return (ph <= PH_CHALLENGE) ? hdr_idx_t'(ph) : IDX_UPGRADE;
  endfunction

  assign c              = in_chan.rx_byte;
  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign accept         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign cur_idx   = hdr_idx_t'(phase_r);
  assign len_inc   = (cur_len == LEN_MAX) ? cur_len : cur_len + 1'b1;
  assign len_plus1 = {1'b0, cur_len} + 1'b1;
  assign grown     = {1'b0, value_room_r} + {1'b0, growth_step_r};

  assign rd_addr    = len_addr(accept ? phase_nxt : phase_r);
  assign len_wr_g   = '{en: len_wr.en && accept, addr: len_wr.addr, data: len_wr.data};
  assign name_ctl_g = '{step: name_ctl.step && accept, clear: name_ctl.clear && accept};

  uhp_name_match u_name (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (name_ctl_g),
    .rx_byte (c),
    .res     (nres)
  );

  uhp_len_store u_len (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (len_wr_g),
    .rd_addr (rd_addr),
    .rd_len  (cur_len)
  );

  // next phase and result of the byte on the input
  always_comb begin
    phase_nxt = phase_r;
    room_nxt  = value_room_r;
    res       = '0;
    len_wr    = '0;
    name_ctl  = '0;
    abandon   = 1'b0;
    case (phase_r)
      PH_URI, PH_HOST, PH_CONNECTION, PH_KEY1, PH_KEY2, PH_PROTOCOL,
      PH_UPGRADE, PH_ORIGIN, PH_DRAFT, PH_CHALLENGE: begin
        if (cur_len == '0 && c == CH_SP) begin
          // leading space dropped
        end else if (phase_r == PH_URI && c == CH_SP) begin
          res.header_index = cur_idx;
          res.value_end    = 1'b1;
          phase_nxt        = PH_SKIP;
        end else begin
          // room grows each time the value fills it
          if (len_plus1 == {1'b0, value_room_r}) begin
            room_nxt = (grown > {1'b0, LEN_MAX}) ? LEN_MAX : grown[LEN_W-1:0];
            abandon  = (grown >= {1'b0, max_room_r});
          end
          if (abandon) begin
            res.header_index   = cur_idx;
            res.value_overflow = 1'b1;
            phase_nxt          = PH_SKIP;
          end else if (phase_r != PH_CHALLENGE && c == CH_CR) begin
            res.header_index = cur_idx;
            res.value_end    = 1'b1;
            phase_nxt        = PH_SKIP_CR;
          end else begin
            res.value_valid  = 1'b1;
            res.header_index = cur_idx;
            res.value_byte   = c;
            len_wr           = '{en: 1'b1, addr: cur_idx, data: len_inc};
            if (phase_r == PH_CHALLENGE && len_inc == LEN_W'(CHALLENGE_BYTES)) begin
              res.value_end  = 1'b1;
              res.parse_done = 1'b1;
              phase_nxt      = PH_DONE;
            end
          end
        end
      end
      PH_NAME: begin
        if (nres.full) begin
          res.name_too_long = 1'b1;
          phase_nxt         = PH_SKIP;
        end else begin
          name_ctl.step = 1'b1;
          if (nres.hit) begin
            phase_nxt = phase_t'(nres.idx);
            room_nxt  = initial_room_r;
            len_wr    = '{en: 1'b1, addr: nres.idx, data: '0};
            // blank line with no upgrade value: nothing more to take
            if (nres.idx == IDX_CHALLENGE && cur_len == '0) begin
              res.header_index = IDX_CHALLENGE;
              res.parse_done   = 1'b1;
              phase_nxt        = PH_DONE;
            end
          end else if (c == CH_COLON) begin
            res.unknown_header = 1'b1;
            phase_nxt          = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (c == CH_CR) begin
          phase_nxt = PH_SKIP_CR;
        end
      end
      PH_SKIP_CR: begin
        phase_nxt      = (c == CH_LF) ? PH_NAME : PH_SKIP;
        name_ctl.clear = 1'b1;
      end
      PH_DONE: begin
        // request complete, bytes ignored
      end
      default: begin
        // unused codes hold
      end
    endcase
  end

  // state, room and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_NAME;
      value_room_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        phase_r      <= phase_nxt;
        value_room_r <= room_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      out_item_r <= res;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_room_r <= LEN_W'(256);
      growth_step_r  <= LEN_W'(64);
      max_room_r     <= LEN_W'(4096);
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.index)
        CFG_INITIAL_ROOM: initial_room_r <= cfg_chan.data;
        CFG_GROWTH_STEP:  growth_step_r  <= cfg_chan.data;
        CFG_MAX_ROOM:     max_room_r     <= cfg_chan.data;
        default: begin
          // index outside the register list
        end
      endcase
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.value_valid    = out_item_r.value_valid;
  assign out_chan.header_index   = out_item_r.header_index;
  assign out_chan.value_byte     = out_item_r.value_byte;
  assign out_chan.value_end      = out_item_r.value_end;
  assign out_chan.value_overflow = out_item_r.value_overflow;
  assign out_chan.unknown_header = out_item_r.unknown_header;
  assign out_chan.name_too_long  = out_item_r.name_too_long;
  assign out_chan.parse_done     = out_item_r.parse_done;

endmodule

>>> sv/uhp_ram.sv
// generic single-port-write ram with registered read
module uhp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/uhp_name_match.sv
// incremental header name matcher, one prefix flag per known name
module uhp_name_match import uhp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  name_ctl_t  ctl,
  input  logic [7:0] rx_byte,
  output name_res_t  res
);

  logic [KNOWN_HEADERS-1:0] match_r;
  logic [KNOWN_HEADERS-1:0] match_nxt;
  logic [KNOWN_HEADERS-1:0] full_hit;
  logic [NAME_LEN_W-1:0]    name_len_r;

  for (genvar k = 0; k < KNOWN_HEADERS; k++) begin : g_hdr
    assign match_nxt[k] = match_r[k] && (int'(name_len_r) < HDR_LEN[k]) &&
                          (rx_byte == hdr_char(k, int'(name_len_r)));
    assign full_hit[k]  = match_nxt[k] && (int'(name_len_r) + 1 == HDR_LEN[k]);
  end

  always_comb begin
    res.full = (name_len_r >= NAME_LEN_W'(NAME_STORE_BYTES - 1));
    res.hit  = |full_hit;
    res.idx  = '0;
    // lowest table index wins
    for (int k = KNOWN_HEADERS - 1; k >= 0; k--) begin
      if (full_hit[k]) begin
        res.idx = hdr_idx_t'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      match_r    <= '1;
      name_len_r <= '0;
    end else if (ctl.step) begin
      match_r    <= match_nxt;
      name_len_r <= name_len_r + 1'b1;
    end
  end

endmodule

>>> sv/uhp_len_store.sv
// value length store: ram, per-entry valid bits and write forwarding
module uhp_len_store import uhp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  len_wr_t  wr,
  input  hdr_idx_t rd_addr,
  output len_t     rd_len
);

  len_t                     rd_data;
  logic [KNOWN_HEADERS-1:0] valid_r;
  hdr_idx_t                 rd_addr_r;
  logic                     fwd_valid_r;
  hdr_idx_t                 fwd_addr_r;
  len_t                     fwd_data_r;

  uhp_ram #(
    .WIDTH (LEN_W),
    .DEPTH (KNOWN_HEADERS)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // a write on the edge of the read is not seen by the ram output
  assign rd_len = (fwd_valid_r && fwd_addr_r == rd_addr_r) ? fwd_data_r :
                  (valid_r[rd_addr_r] ? rd_data : '0);

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr;
    fwd_addr_r <= wr.addr;
    fwd_data_r <= wr.data;
    if (!rst_n) begin
      valid_r     <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= wr.en;
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
    end
  end

endmodule

>>> sv/uhp_checker.sv
// port-level checker of the upgrade header parser and its bind
`include "assert_macros.svh"

module uhp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       value_valid,
  input logic [3:0] header_index,
  input logic [7:0] value_byte,
  input logic       value_end,
  input logic       value_overflow,
  input logic       unknown_header,
  input logic       name_too_long,
  input logic       parse_done
);

  logic [17:0] payload;
  logic        side_flag;

  assign payload   = {value_valid, header_index, value_byte, value_end, value_overflow,
                      unknown_header, name_too_long, parse_done};
  assign side_flag = value_overflow || unknown_header || name_too_long;

  `ASSERT_ON(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(payload))
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)
  `ASSERT_ON(a_result_follows, clk, rst_n, in_valid && in_ready |=> out_valid)
  `ASSERT_ON(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready)
  `ASSERT_ON(a_flags_exclusive, clk, rst_n, out_valid && value_valid |-> !side_flag)

endmodule

bind http_upgrade_header_parser uhp_checker u_uhp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .value_valid    (out_chan.value_valid),
  .header_index   (out_chan.header_index),
  .value_byte     (out_chan.value_byte),
  .value_end      (out_chan.value_end),
  .value_overflow (out_chan.value_overflow),
  .unknown_header (out_chan.unknown_header),
  .name_too_long  (out_chan.name_too_long),
  .parse_done     (out_chan.parse_done)
);
